// File: rtl/feistel_frame_decrypt_check_macros.svh
// Assertion macros shared by the frame decrypt and check RTL.
`ifndef FEISTEL_FRAME_DECRYPT_CHECK_MACROS_SVH
`define FEISTEL_FRAME_DECRYPT_CHECK_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FFDC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define FFDC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/ffdc_pkg.sv
// Types, constants and cipher/CRC functions of the frame decrypt and check block.
package ffdc_pkg;

    localparam int unsigned ROUND_COUNT_DEF = 8;
    localparam int unsigned KEY_WORDS       = 4;
    localparam int unsigned BLOCK_BYTES     = 10;
    localparam int unsigned HALF_W          = 40;
    localparam int unsigned CFG_ADDR_W      = 4;
    localparam int unsigned CFG_DATA_W      = 32;

    localparam logic [7:0]  SUBKEY_MASK = 8'hA5;
    localparam logic [7:0]  POOL_MASK   = 8'h5A;
    localparam logic [7:0]  MIX_ADD     = 8'h3D;
    localparam logic [15:0] CRC_POLY    = 16'h1021;
    localparam logic [15:0] CRC_INIT    = 16'hFFFF;

    typedef enum logic [1:0] {
        REG_KEY_WORD0,
        REG_KEY_WORD1,
        REG_KEY_WORD2,
        REG_KEY_WORD3
    } t_reg_idx;

    localparam logic [CFG_DATA_W-1:0] KEY_RESET [KEY_WORDS] = '{
        32'h582713B1, 32'h01EFCD9A, 32'h88664422, 32'h00EECCAA
    };

    localparam logic [3:0] SBOX [16] = '{
        4'hC, 4'h5, 4'h6, 4'hB, 4'h9, 4'h0, 4'hA, 4'hD,
        4'h3, 4'hE, 4'hF, 4'h8, 4'h4, 4'h7, 4'h1, 4'h2
    };

    localparam int unsigned PERM [BLOCK_BYTES] = '{4, 2, 8, 0, 6, 3, 9, 7, 1, 5};

    typedef logic [HALF_W-1:0] t_half;

    typedef struct packed {
        logic [15:0] frame_word4;
        logic [15:0] frame_word3;
        logic [15:0] frame_word2;
        logic [15:0] frame_word1;
        logic [15:0] frame_word0;
    } t_frame;

    typedef struct packed {
        logic               crc_ok;
        logic [31:0]        uid_word;
        logic signed [15:0] temperature;
        logic [15:0]        humidity;
    } t_result;

    typedef struct packed {
        t_half left;
        t_half right;
    } t_block;

    typedef logic [63:0][15:0] t_crc_cols;

    // out byte i = in byte PERM[i]
    function automatic logic [79:0] permute(logic [79:0] src);
        logic [79:0] dst;
        for (int i = 0; i < BLOCK_BYTES; i++) begin
            dst[8*i +: 8] = src[8*PERM[i] +: 8];
        end
        return dst;
    endfunction

    function automatic logic [7:0] sub_byte(logic [7:0] v);
        return {SBOX[v[7:4]], SBOX[v[3:0]]};
    endfunction

    // Byte n of the unrolled key pool: each wrap past the end mixes in a round mask.
    function automatic logic [7:0] pool_byte(logic [127:0] key, int unsigned n);
        logic [7:0] b;
        b = key[8*(n & 15) +: 8];
        for (int t = 1; t < 3; t++) begin
            if (n >= 16*t) begin
                b = b ^ (POOL_MASK ^ 8'(n - 16*t));
            end
        end
        return b;
    endfunction

    function automatic t_half subkey(logic [127:0] key, int unsigned r);
        t_half sk;
        for (int unsigned i = 0; i < 5; i++) begin
            sk[8*i +: 8] = pool_byte(key, r + ((r + i) & 15)) ^
                           (SUBKEY_MASK ^ 8'((r*13 + i*7) & 255));
        end
        return sk;
    endfunction

    function automatic t_half round_fn(t_half half, t_half key, int unsigned amt);
        t_half      word;
        t_half      rot;
        logic [7:0] b0;
        logic [7:0] b2;
        for (int i = 0; i < 5; i++) begin
            word[8*i +: 8] = sub_byte(half[8*i +: 8] ^ key[8*i +: 8]);
        end
        if (amt == 0) begin
            rot = word;
        end else begin
            rot = (word << amt) | (word >> (HALF_W - amt));
        end
        b0 = rot[7:0] ^ (rot[39:32] + MIX_ADD);
        b2 = rot[23:16] ^ (b0 + rot[15:8]);
        return {rot[39:24], b2, rot[15:8], b0};
    endfunction

    // Bitwise CRC, MSB first; only evaluated on constants.
    function automatic logic [15:0] crc_run(logic [63:0] msg, logic [15:0] init);
        logic [15:0] crc;
        crc = init;
        for (int i = 0; i < 8; i++) begin
            crc = crc ^ {msg[8*i +: 8], 8'h00};
            for (int b = 0; b < 8; b++) begin
                crc = crc[15] ? ((crc << 1) ^ CRC_POLY) : (crc << 1);
            end
        end
        return crc;
    endfunction

    function automatic t_crc_cols crc_cols_build();
        t_crc_cols cols;
        for (int j = 0; j < 64; j++) begin
            cols[j] = crc_run(64'(1) << j, 16'h0000);
        end
        return cols;
    endfunction

    localparam t_crc_cols   CRC_COLS = crc_cols_build();
    localparam logic [15:0] CRC_BASE = crc_run(64'h0, CRC_INIT);

    // CRC is linear: base term for the init value, one column per set message bit.
    function automatic logic [15:0] crc_calc(logic [63:0] msg);
        logic [15:0] crc;
        crc = CRC_BASE;
        for (int j = 0; j < 64; j++) begin
            if (msg[j]) begin
                crc = crc ^ CRC_COLS[j];
            end
        end
        return crc;
    endfunction

endpackage

// File: rtl/ffdc_key_sched.sv
// Key registers on the APB port and the registered round subkey table.
`include "feistel_frame_decrypt_check_macros.svh"

module ffdc_key_sched #(
    parameter int unsigned ROUND_COUNT = ffdc_pkg::ROUND_COUNT_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [ffdc_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [ffdc_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [ffdc_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                                pready,
    output logic [ROUND_COUNT-1:0][ffdc_pkg::HALF_W-1:0] o_subkey
);

    logic [ffdc_pkg::CFG_DATA_W-1:0] r_key [ffdc_pkg::KEY_WORDS];
    logic [ROUND_COUNT-1:0][ffdc_pkg::HALF_W-1:0] r_subkey;
    logic [ROUND_COUNT-1:0][ffdc_pkg::HALF_W-1:0] n_subkey;
    logic                  wr_en;
    ffdc_pkg::t_reg_idx    reg_idx;
    logic [127:0]          key_all;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = ffdc_pkg::t_reg_idx'(paddr[3:2]);
    assign key_all = {r_key[3], r_key[2], r_key[1], r_key[0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < ffdc_pkg::KEY_WORDS; i++) begin
                r_key[i] <= ffdc_pkg::KEY_RESET[i];
            end
        end else if (wr_en) begin
            unique case (reg_idx)
                ffdc_pkg::REG_KEY_WORD0: r_key[0] <= pwdata;
                ffdc_pkg::REG_KEY_WORD1: r_key[1] <= pwdata;
                ffdc_pkg::REG_KEY_WORD2: r_key[2] <= pwdata;
                ffdc_pkg::REG_KEY_WORD3: r_key[3] <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            ffdc_pkg::REG_KEY_WORD0: prdata = r_key[0];
            ffdc_pkg::REG_KEY_WORD1: prdata = r_key[1];
            ffdc_pkg::REG_KEY_WORD2: prdata = r_key[2];
            ffdc_pkg::REG_KEY_WORD3: prdata = r_key[3];
            default:                 prdata = '0;
        endcase
    end

    // Subkeys follow key writes; user must keep the pipe empty then; not enforced.
    always_comb begin
        for (int unsigned r = 0; r < ROUND_COUNT; r++) begin
            n_subkey[r] = ffdc_pkg::subkey(key_all, r);
        end
    end

    always_ff @(posedge i_clk) begin
        r_subkey <= n_subkey;
    end

    assign o_subkey = r_subkey;

    `FFDC_ASSERT_NXT(a_key_write, i_clk, i_rst_n, wr_en, (r_key[$past(paddr[3:2])] == $past(pwdata)), "key register does not hold written word")

endmodule

// File: rtl/ffdc_round_stage.sv
// One registered Feistel decryption round with its own valid and ready.
`include "feistel_frame_decrypt_check_macros.svh"

module ffdc_round_stage #(
    parameter int unsigned RND_NUM = 0
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  ffdc_pkg::t_block i_block,
    input  ffdc_pkg::t_half  i_subkey,
    output logic             o_valid,
    input  logic             i_ready,
    output ffdc_pkg::t_block o_block
);

    localparam int unsigned ROT = (RND_NUM + 1) % ffdc_pkg::HALF_W;

    logic             r_valid;
    ffdc_pkg::t_block r_block;
    ffdc_pkg::t_block n_block;
    ffdc_pkg::t_half  mix;
    logic             load;

    assign o_ready = !r_valid || i_ready;
    assign load    = i_valid && o_ready;

    // Swap halves, then fold the round function of the old left into the new left.
    always_comb begin
        mix           = ffdc_pkg::round_fn(i_block.left, i_subkey, ROT);
        n_block.left  = i_block.right ^ mix;
        n_block.right = i_block.left;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_block <= n_block;
        end
    end

    assign o_valid = r_valid;
    assign o_block = r_block;

    `FFDC_ASSERT_NXT(a_stage_hold, i_clk, i_rst_n, (r_valid && !i_ready),
        (r_valid && $stable(r_block)), "stalled round stage lost or changed its item")

endmodule

// File: rtl/ffdc_check_stage.sv
// Output permutation, CRC check and the registered result.
`include "feistel_frame_decrypt_check_macros.svh"

module ffdc_check_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  ffdc_pkg::t_block  i_block,
    output logic              o_valid,
    input  logic              i_ready,
    output ffdc_pkg::t_result o_result
);

    logic              r_valid;
    ffdc_pkg::t_result r_result;
    ffdc_pkg::t_result n_result;
    logic [79:0]       plain;
    logic [15:0]       crc;
    logic              match;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        plain = ffdc_pkg::permute({i_block.right, i_block.left});
        crc   = ffdc_pkg::crc_calc(plain[63:0]);
        match = (crc == plain[79:64]);
        n_result.crc_ok = match;
        if (match) begin
            n_result.uid_word    = plain[31:0];
            n_result.temperature = $signed(plain[47:32]);
            n_result.humidity    = plain[63:48];
        end else begin
            n_result.uid_word    = '0;
            n_result.temperature = '0;
            n_result.humidity    = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_result <= n_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

    `FFDC_ASSERT_IMP(a_zero_on_fail, i_clk, i_rst_n, (r_valid && !r_result.crc_ok),
        ((r_result.uid_word == '0) && (r_result.temperature == '0) &&
         (r_result.humidity == '0)), "failed frame carries data")

endmodule

// File: rtl/feistel_frame_decrypt_check.sv
// Top level of the frame decrypt and check pipeline.
//
// Use: present a 10-byte encrypted frame on i_in_data with i_in_valid; it is
// taken on an edge where o_in_ready is also high. Each frame gives exactly one
// result on o_out_data, taken on an edge where o_out_valid and i_out_ready
// are both high. The 128-bit key sits in four 32-bit registers on the APB
// port (byte addresses 0, 4, 8, 12); write them only while no frame is in
// flight.
// Pipeline: one input register, one register stage per round, one stage for
// the output permutation and CRC check. A new frame can be taken every cycle
// as long as the output is not stalled. Every stage has its own valid bit and
// ready, so a stalled receiver fills the bubbles first; input ready drops
// only once all ROUND_COUNT + 2 stages hold a frame. Nothing is dropped or
// repeated under stall. Reset clears all valid bits and loads the default
// key; the subkey table is registered from the key registers and follows
// any key write.
`include "feistel_frame_decrypt_check_macros.svh"

module feistel_frame_decrypt_check #(
    parameter int unsigned ROUND_COUNT = ffdc_pkg::ROUND_COUNT_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  ffdc_pkg::t_frame                i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output ffdc_pkg::t_result               o_out_data,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [ffdc_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [ffdc_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [ffdc_pkg::CFG_DATA_W-1:0] prdata,
    output logic                            pready
);

    logic [ROUND_COUNT-1:0][ffdc_pkg::HALF_W-1:0] subkey;
    logic [ROUND_COUNT:0] stage_valid;
    logic [ROUND_COUNT:0] stage_ready;
    ffdc_pkg::t_block     stage_block [ROUND_COUNT+1];

    logic             r_in_valid;
    ffdc_pkg::t_frame r_frame;
    logic [79:0]      work;

    ffdc_key_sched #(
        .ROUND_COUNT (ROUND_COUNT)
    ) u_key_sched (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .o_subkey (subkey)
    );

    assign o_in_ready = !r_in_valid || stage_ready[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_frame <= i_in_data;
        end
    end

    // Cipher bytes come in little endian; permute, low five bytes form the right half.
    assign work                 = ffdc_pkg::permute(r_frame);
    assign stage_valid[0]       = r_in_valid;
    assign stage_block[0].right = work[39:0];
    assign stage_block[0].left  = work[79:40];

    // Subkeys run in reverse: the first stage uses the last round's key.
    for (genvar k = 0; k < ROUND_COUNT; k++) begin : g_round
        ffdc_round_stage #(
            .RND_NUM (ROUND_COUNT - 1 - k)
        ) u_round (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_valid  (stage_valid[k]),
            .o_ready  (stage_ready[k]),
            .i_block  (stage_block[k]),
            .i_subkey (subkey[ROUND_COUNT - 1 - k]),
            .o_valid  (stage_valid[k+1]),
            .i_ready  (stage_ready[k+1]),
            .o_block  (stage_block[k+1])
        );
    end

    ffdc_check_stage u_check (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (stage_valid[ROUND_COUNT]),
        .o_ready  (stage_ready[ROUND_COUNT]),
        .i_block  (stage_block[ROUND_COUNT]),
        .o_valid  (o_out_valid),
        .i_ready  (i_out_ready),
        .o_result (o_out_data)
    );

    `FFDC_ASSERT_IMP(a_full_only_on_stall, i_clk, i_rst_n, !o_in_ready,
        (o_out_valid && !i_out_ready), "input blocked while output is not stalled")

endmodule

// File: test/tb_top.sv
// Self-checking testbench for the frame decrypt and CRC check pipeline.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ROUNDS     = 8;
    localparam int LATENCY    = ROUNDS + 2;
    localparam int CYCLE_CAP  = 200000;
    localparam int MAX_GAP    = 11;

    localparam int         BYTE_ORDER [10] = '{4, 2, 8, 0, 6, 3, 9, 7, 1, 5};
    localparam logic [3:0] NIBBLE_SUB [16] = '{
        4'hC, 4'h5, 4'h6, 4'hB, 4'h9, 4'h0, 4'hA, 4'hD,
        4'h3, 4'hE, 4'hF, 4'h8, 4'h4, 4'h7, 4'h1, 4'h2
    };
    localparam logic [7:0]  SK_TWEAK   = 8'hA5;
    localparam logic [7:0]  POOL_TWEAK = 8'h5A;
    localparam logic [7:0]  MIX_BIAS   = 8'h3D;
    localparam logic [15:0] CRC_SEED   = 16'hFFFF;
    localparam logic [15:0] CRC_GEN    = 16'h1021;

    typedef logic [ROUNDS-1:0][39:0] t_subkey_set;

    class frame_check_board;
        logic [31:0]       key_words [4];
        ffdc_pkg::t_result due_results [$];
        int                mismatches;

        function new();
            key_words  = '{32'h582713B1, 32'h01EFCD9A, 32'h88664422, 32'h00EECCAA};
            mismatches = 0;
        endfunction

        function void set_key(ffdc_pkg::t_reg_idx idx, logic [31:0] value);
            key_words[idx] = value;
        endfunction

        // Byte pool rotates left once per round, wrapping byte tweaked by round.
        function t_subkey_set expand_key();
            t_subkey_set sk;
            logic [7:0]  pool [16];
            logic [7:0]  first;
            for (int i = 0; i < 16; i++) begin
                pool[i] = key_words[i >> 2][8*(i & 3) +: 8];
            end
            for (int r = 0; r < ROUNDS; r++) begin
                for (int i = 0; i < 5; i++) begin
                    sk[r][8*i +: 8] = pool[(r + i) & 15] ^ (SK_TWEAK ^ 8'((r*13 + i*7) & 255));
                end
                first = pool[0];
                for (int j = 0; j < 15; j++) begin
                    pool[j] = pool[j+1];
                end
                pool[15] = first ^ (POOL_TWEAK ^ 8'(r));
            end
            return sk;
        endfunction

        function logic [39:0] round_mix(logic [39:0] half, logic [39:0] k, int rnd);
            logic [39:0] w;
            logic [39:0] rot;
            logic [7:0]  x;
            logic [7:0]  b0;
            logic [7:0]  b2;
            int          amt;
            for (int i = 0; i < 5; i++) begin
                x = half[8*i +: 8] ^ k[8*i +: 8];
                w[8*i +: 8] = {NIBBLE_SUB[x[7:4]], NIBBLE_SUB[x[3:0]]};
            end
            amt = (rnd + 1) % 40;
            rot = (amt == 0) ? w : ((w << amt) | (w >> (40 - amt)));
            b0 = rot[7:0] ^ (rot[39:32] + MIX_BIAS);
            b2 = rot[23:16] ^ (b0 + rot[15:8]);
            return {rot[39:24], b2, rot[15:8], b0};
        endfunction

        // Forward: out byte i = in byte BYTE_ORDER[i]; undo applies the inverse.
        function logic [79:0] shuffle(logic [79:0] x, bit undo);
            logic [79:0] y;
            for (int i = 0; i < 10; i++) begin
                if (undo) begin
                    y[8*BYTE_ORDER[i] +: 8] = x[8*i +: 8];
                end else begin
                    y[8*i +: 8] = x[8*BYTE_ORDER[i] +: 8];
                end
            end
            return y;
        endfunction

        function logic [15:0] crc16(logic [63:0] body);
            logic [15:0] crc;
            crc = CRC_SEED;
            for (int i = 0; i < 8; i++) begin
                crc = crc ^ {body[8*i +: 8], 8'h00};
                for (int b = 0; b < 8; b++) begin
                    crc = crc[15] ? ((crc << 1) ^ CRC_GEN) : (crc << 1);
                end
            end
            return crc;
        endfunction

        function logic [79:0] decrypt(logic [79:0] cipher);
            t_subkey_set sk;
            logic [79:0] w;
            logic [39:0] lh;
            logic [39:0] rh;
            logic [39:0] t;
            sk = expand_key();
            w  = shuffle(cipher, 1'b0);
            rh = w[39:0];
            lh = w[79:40];
            for (int r = ROUNDS - 1; r >= 0; r--) begin
                t  = lh;
                lh = rh;
                rh = t;
                lh = lh ^ round_mix(rh, sk[r], r);
            end
            return shuffle({rh, lh}, 1'b0);
        endfunction

        // Walk the rounds in the reverse order of decrypt() so that decrypt() returns the given plaintext.
        function logic [79:0] encrypt(logic [79:0] plain);
            t_subkey_set sk;
            logic [79:0] w;
            logic [39:0] lh;
            logic [39:0] rh;
            logic [39:0] t;
            sk = expand_key();
            w  = shuffle(plain, 1'b1);
            lh = w[39:0];
            rh = w[79:40];
            for (int r = 0; r < ROUNDS; r++) begin
                t  = rh;
                rh = lh ^ round_mix(rh, sk[r], r);
                lh = t;
            end
            return shuffle({lh, rh}, 1'b1);
        endfunction

        function logic [79:0] seal(logic [63:0] body);
            return encrypt({crc16(body), body});
        endfunction

        function void note_frame(ffdc_pkg::t_frame f);
            logic [79:0]       p;
            ffdc_pkg::t_result r;
            p = decrypt(f);
            r = '0;
            if (crc16(p[63:0]) == p[79:64]) begin
                r.crc_ok      = 1'b1;
                r.uid_word    = p[31:0];
                r.temperature = p[47:32];
                r.humidity    = p[63:48];
            end
            due_results.push_back(r);
        endfunction

        function void check_result(ffdc_pkg::t_result got);
            ffdc_pkg::t_result want;
            if (due_results.size() == 0) begin
                $error("result with no frame outstanding: %h", got);
                mismatches++;
                return;
            end
            want = due_results.pop_front();
            if (got.crc_ok !== want.crc_ok) begin
                $error("crc_ok: expected %0d, got %0d", want.crc_ok, got.crc_ok);
                mismatches++;
            end
            if (got.uid_word !== want.uid_word) begin
                $error("uid_word: expected %h, got %h", want.uid_word, got.uid_word);
                mismatches++;
            end
            if (got.temperature !== want.temperature) begin
                $error("temperature: expected %0d, got %0d", want.temperature, got.temperature);
                mismatches++;
            end
            if (got.humidity !== want.humidity) begin
                $error("humidity: expected %h, got %h", want.humidity, got.humidity);
                mismatches++;
            end
        endfunction
    endclass

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_in_valid  = 1'b0;
    ffdc_pkg::t_frame  i_in_data   = '0;
    logic              i_out_ready = 1'b0;
    logic              psel        = 1'b0;
    logic              penable     = 1'b0;
    logic              pwrite      = 1'b0;
    logic [3:0]        paddr       = '0;
    logic [31:0]       pwdata      = '0;
    logic              o_in_ready;
    logic              o_out_valid;
    ffdc_pkg::t_result o_out_data;
    logic [31:0]       prdata;
    logic              pready;

    frame_check_board sb;
    bit               steady;
    int               cycles;

    feistel_frame_decrypt_check #(.ROUND_COUNT(ROUNDS)) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_CAP) begin
            $display("FAIL");
            $finish;
        end
    end

    function int draw_gap();
        return steady ? 0 : $urandom_range(0, MAX_GAP);
    endfunction

    task automatic send_frame(ffdc_pkg::t_frame f);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= f;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_frame(f);
    endtask

    task automatic apb_write(ffdc_pkg::t_reg_idx idx, logic [31:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_key(idx, value);
    endtask

    task automatic load_key(logic [31:0] w0, logic [31:0] w1, logic [31:0] w2,
                            logic [31:0] w3);
        apb_write(ffdc_pkg::REG_KEY_WORD0, w0);
        apb_write(ffdc_pkg::REG_KEY_WORD1, w1);
        apb_write(ffdc_pkg::REG_KEY_WORD2, w2);
        apb_write(ffdc_pkg::REG_KEY_WORD3, w3);
    endtask

    // Valid must already be low: wait out every result, then the pipeline depth.
    task automatic wait_drain();
        while (sb.due_results.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 2) @(posedge i_clk);
    endtask

    // Mostly well-formed frames with random content, the rest corrupted or raw noise.
    function ffdc_pkg::t_frame next_frame();
        logic [79:0] bits;
        int          pick;
        pick = $urandom_range(0, 99);
        if (pick < 85) begin
            bits = sb.seal({$urandom, $urandom});
            if (pick >= 70) begin
                bits[$urandom_range(0, 79)] ^= 1'b1;
            end
        end else begin
            bits = {16'($urandom), $urandom, $urandom};
        end
        return ffdc_pkg::t_frame'(bits);
    endfunction

    task automatic run_frames(int count, int hold_at);
        for (int n = 0; n < count; n++) begin
            if (n == hold_at) begin
                i_in_valid <= 1'b0;
                do @(posedge i_clk); while (sb.due_results.size() != 0);
            end
            send_frame(next_frame());
        end
        i_in_valid <= 1'b0;
    endtask

    task automatic run_directed();
        logic [63:0] bodies [9];
        logic [79:0] bad;
        bodies = '{
            {16'h0000, 16'h0000, 32'h00000000},
            {16'hFFFF, 16'h7FFF, 32'hFFFFFFFF},
            {16'h0000, 16'h8000, 32'h00000001},
            {16'h8000, 16'hFFFF, 32'h80000000},
            {16'h0001, 16'h0001, 32'h7FFFFFFF},
            {16'hA5A5, 16'h5A5A, 32'hA5A5A5A5},
            {16'h5A5A, 16'hA5A5, 32'h5A5A5A5A},
            {16'h1234, 16'hFE0C, 32'hDEADBEEF},
            {16'hFFFF, 16'h0000, 32'h00FF00FF}
        };
        send_frame(ffdc_pkg::t_frame'(80'h0));
        send_frame(ffdc_pkg::t_frame'({80{1'b1}}));
        foreach (bodies[k]) begin
            send_frame(ffdc_pkg::t_frame'(sb.seal(bodies[k])));
        end
        // Checksum field with its lowest or its highest bit flipped after a clean decrypt.
        send_frame(ffdc_pkg::t_frame'(sb.encrypt({sb.crc16(bodies[7]) ^ 16'h0001,
                                                  bodies[7]})));
        send_frame(ffdc_pkg::t_frame'(sb.encrypt({sb.crc16(bodies[1]) ^ 16'h8000,
                                                  bodies[1]})));
        // Flip the lowest or the highest cipher bit of a good frame, one frame each.
        bad = sb.seal(bodies[5]);
        send_frame(ffdc_pkg::t_frame'(bad ^ 80'h1));
        send_frame(ffdc_pkg::t_frame'(bad ^ {1'b1, 79'h0}));
        send_frame(ffdc_pkg::t_frame'(80'h5555_5555_5555_5555_5555));
        send_frame(ffdc_pkg::t_frame'(80'hAAAA_AAAA_AAAA_AAAA_AAAA));
        i_in_valid <= 1'b0;
    endtask

    // Receiver: random stall before each transfer, check at the handshake.
    initial begin
        int stall;
        wait (i_rst_n);
        forever begin
            stall = draw_gap();
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            sb.check_result(o_out_data);
        end
    end

    initial begin
        steady = 1'b0;
        sb     = new();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_directed();
        wait_drain();

        load_key(32'h0, 32'h0, 32'h0, 32'h0);
        steady = 1'b1;
        run_frames(80, -1);
        wait_drain();

        load_key(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
        steady = 1'b0;
        run_frames(80, 40);
        wait_drain();

        load_key($urandom, $urandom, $urandom, $urandom);
        run_frames(120, -1);
        wait_drain();

        load_key(32'h0, 32'hFFFFFFFF, $urandom, $urandom);
        run_frames(120, 60);
        wait_drain();

        if (sb.mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule
